/* design/ampd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ampd_pkg
// Shared types, constants and the CRC-32 byte update of the deaggregator.
// ----------------------------------------------------------------------------
package ampd_pkg;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [11:0] psdu_length;
    logic        aggregated;
  } in_t;

  typedef struct packed {
    logic [11:0] mpdu_offset;
    logic [11:0] mpdu_length;
    logic        fcs_ok;
    logic        from_aggregate;
  } out_t;

  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;
  localparam logic [31:0] GOOD_FCS    = 32'h2144DF1C;
  localparam logic [12:0] DELIM_BYTES = 13'd4;

  // reflected crc-32, one byte, lsb first
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

endpackage

/* design/ampd_in_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ampd_in_reg
// Input register: holds one accepted byte request until the parser takes it.
// ----------------------------------------------------------------------------
module ampd_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ampd_pkg::in_t in_data,
  input  logic          take,
  output logic          item_valid,
  output ampd_pkg::in_t item
);

  logic          valid_r;
  logic          valid_nxt;
  ampd_pkg::in_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

endmodule

/* design/ampd_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ampd_parser
// Delimiter parser and FCS check: one byte per step, result decided in the
// same step.
// ----------------------------------------------------------------------------
module ampd_parser #(
  parameter int unsigned MAX_PSDU_BYTES = 4095
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  ampd_pkg::in_t  item,
  output logic           res_valid,
  output ampd_pkg::out_t res
);

  localparam logic [1:0] PH_DONE    = 2'd0;
  localparam logic [1:0] PH_PLAIN   = 2'd1;
  localparam logic [1:0] PH_DELIM   = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  localparam int unsigned CLAMP_LEN = (MAX_PSDU_BYTES > 4095) ? 4095 : MAX_PSDU_BYTES;

  logic [31:0] crc_r,    crc_nxt;
  logic [11:0] pos_r,    pos_nxt;
  logic [1:0]  phase_r,  phase_nxt;
  logic [1:0]  didx_r,   didx_nxt;
  logic        eof_r,    eof_nxt;
  logic [13:0] dlen_r,   dlen_nxt;
  logic [13:0] prem_r,   prem_nxt;
  logic [11:0] pstart_r, pstart_nxt;
  logic [11:0] hlen_r,   hlen_nxt;
  logic        hmode_r,  hmode_nxt;

  always_comb begin
    crc_nxt    = crc_r;
    pos_nxt    = pos_r;
    phase_nxt  = phase_r;
    didx_nxt   = didx_r;
    eof_nxt    = eof_r;
    dlen_nxt   = dlen_r;
    prem_nxt   = prem_r;
    pstart_nxt = pstart_r;
    hlen_nxt   = hlen_r;
    hmode_nxt  = hmode_r;
    res_valid  = 1'b0;
    res        = '0;

    if (item.first_byte) begin
      hlen_nxt   = (item.psdu_length > 12'(CLAMP_LEN)) ? 12'(CLAMP_LEN) : item.psdu_length;
      hmode_nxt  = item.aggregated;
      pos_nxt    = '0;
      eof_nxt    = 1'b0;
      didx_nxt   = '0;
      dlen_nxt   = '0;
      prem_nxt   = '0;
      pstart_nxt = '0;
      crc_nxt    = ampd_pkg::CRC_INIT;
      if (hlen_nxt == 12'd0) begin
        phase_nxt = PH_DONE;
      end else begin
        phase_nxt = item.aggregated ? PH_DELIM : PH_PLAIN;
      end
    end

    unique case (phase_nxt)
      PH_PLAIN: begin
        crc_nxt = ampd_pkg::crc_byte(crc_nxt, item.data_byte);
        if ({1'b0, pos_nxt} + 13'd1 >= {1'b0, hlen_nxt}) begin
          res_valid = 1'b1;
          res.mpdu_offset    = '0;
          res.mpdu_length    = hlen_nxt;
          res.fcs_ok         = (~crc_nxt == ampd_pkg::GOOD_FCS);
          res.from_aggregate = 1'b0;
          phase_nxt = PH_DONE;
        end
        pos_nxt = pos_nxt + 12'd1;
      end
      PH_DELIM: begin
        if (didx_nxt == 2'd0 &&
            {1'b0, hlen_nxt} < {1'b0, pos_nxt} + ampd_pkg::DELIM_BYTES) begin
          // short aggregate tail
          phase_nxt = PH_DONE;
        end else if (didx_nxt == 2'd3 &&
                     {3'd0, hlen_nxt} < 15'(pos_nxt) + 15'd1 + 15'(dlen_nxt)) begin
          // mpdu would overrun the psdu
          phase_nxt = PH_DONE;
          didx_nxt  = '0;
        end else begin
          case (didx_nxt)
            2'd0: begin
              eof_nxt  = item.data_byte[0];
              dlen_nxt = {item.data_byte[3:2], 8'd0, item.data_byte[7:4]};
            end
            2'd1: begin
              dlen_nxt = dlen_nxt | {2'd0, item.data_byte, 4'd0};
            end
            2'd3: begin
              crc_nxt = ampd_pkg::CRC_INIT;
              if (dlen_nxt == 14'd0) begin
                res_valid = 1'b1;
                res.mpdu_offset    = pos_nxt + 12'd1;
                res.mpdu_length    = '0;
                res.fcs_ok         = (~crc_nxt == ampd_pkg::GOOD_FCS);
                res.from_aggregate = 1'b1;
                if (eof_nxt) begin
                  phase_nxt = PH_DONE;
                end
              end else begin
                phase_nxt  = PH_PAYLOAD;
                prem_nxt   = dlen_nxt;
                pstart_nxt = pos_nxt + 12'd1;
              end
            end
            default: begin
            end
          endcase
          didx_nxt = didx_nxt + 2'd1;
          pos_nxt  = pos_nxt + 12'd1;
        end
      end
      PH_PAYLOAD: begin
        crc_nxt  = ampd_pkg::crc_byte(crc_nxt, item.data_byte);
        prem_nxt = prem_nxt - 14'd1;
        if (prem_nxt == 14'd0) begin
          res_valid = 1'b1;
          res.mpdu_offset    = pstart_nxt;
          res.mpdu_length    = dlen_nxt[11:0];
          res.fcs_ok         = (~crc_nxt == ampd_pkg::GOOD_FCS);
          res.from_aggregate = 1'b1;
          phase_nxt = eof_nxt ? PH_DONE : PH_DELIM;
          didx_nxt  = '0;
        end
        pos_nxt = pos_nxt + 12'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= ampd_pkg::CRC_INIT;
      pos_r    <= '0;
      phase_r  <= PH_DONE;
      didx_r   <= '0;
      eof_r    <= 1'b0;
      dlen_r   <= '0;
      prem_r   <= '0;
      pstart_r <= '0;
      hlen_r   <= '0;
      hmode_r  <= 1'b0;
    end else if (step) begin
      crc_r    <= crc_nxt;
      pos_r    <= pos_nxt;
      phase_r  <= phase_nxt;
      didx_r   <= didx_nxt;
      eof_r    <= eof_nxt;
      dlen_r   <= dlen_nxt;
      prem_r   <= prem_nxt;
      pstart_r <= pstart_nxt;
      hlen_r   <= hlen_nxt;
      hmode_r  <= hmode_nxt;
    end
  end

endmodule

/* design/ampd_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ampd_out_reg
// Result register: holds one MPDU report until the receiver takes it.
// ----------------------------------------------------------------------------
module ampd_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  ampd_pkg::out_t res,
  output logic           slot_free,
  output logic           out_valid,
  input  logic           out_ready,
  output ampd_pkg::out_t out_data
);

  logic           valid_r;
  logic           valid_nxt;
  ampd_pkg::out_t data_r;

  assign slot_free = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (slot_free) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && slot_free) begin
      data_r <= res;
    end
  end

endmodule

/* design/ampdu_deaggregator_fcs_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ampdu_deaggregator_fcs_check
// Splits a decoded PSDU into MPDUs and checks the CRC-32 FCS of each.
//
// Input channel (in_valid/in_ready/in_data): one PSDU byte per request; the
// first byte carries first_byte, psdu_length and aggregated.
// Result channel (out_valid/out_ready/out_data): one report per MPDU with
// its offset, length, FCS verdict and aggregate flag, given at its last byte.
//
// Throughput: one byte per cycle while the result register has room. The CRC
// byte update and the delimiter parse sit in combinational logic between the
// input register and the result register. A byte accepted into the input
// register is parsed from there, and its result is loaded into the result
// register and shown on out_valid when that register has room.
// When the receiver stalls, the result register holds its report and one
// more byte may wait in the input register; then in_ready drops.
// Reset (rst_n low, synchronous) empties both registers and leaves the
// parser waiting for a first byte.
// ----------------------------------------------------------------------------
module ampdu_deaggregator_fcs_check #(
  parameter int unsigned MAX_PSDU_BYTES = 4095
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ampd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ampd_pkg::out_t out_data
);

  logic           item_valid;
  ampd_pkg::in_t  item;
  logic           slot_free;
  logic           advance;
  logic           res_valid;
  ampd_pkg::out_t res;

  // a byte moves on only when the result register has room
  assign advance = item_valid && slot_free;

  ampd_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ampd_parser #(
    .MAX_PSDU_BYTES (MAX_PSDU_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  ampd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* design/ampd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ampd_checker
// Port-level checks of the deaggregator, bound to the top level.
// ----------------------------------------------------------------------------
module ampd_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input ampd_pkg::out_t out_data
);

  // a stalled report holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an empty result register never blocks input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_plain_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.from_aggregate |-> out_data.mpdu_offset == 12'd0)
    else $error("plain mpdu with nonzero offset");

  a_empty_mpdu: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.from_aggregate && out_data.mpdu_length == 12'd0
    |-> !out_data.fcs_ok)
    else $error("zero-length mpdu flagged good");

endmodule

bind ampdu_deaggregator_fcs_check ampd_checker u_ampd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives decoded PSDU bytes into ampdu_deaggregator_fcs_check, plain and
// delimiter-framed, and checks every MPDU report in order against a local
// byte-level parser with its own CRC-32, under random source and sink stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam int STALL_LIMIT = 4000;

  typedef enum logic [1:0] {PARSE_IDLE, PARSE_PLAIN, PARSE_DELIM, PARSE_BODY} parse_e;
  typedef enum int {RX_FREE, RX_HALF, RX_SPARSE, RX_BEAT} rx_mode_e;

  typedef struct {
    ampd_pkg::in_t req;
    bit            hold_for_drain;
  } byte_req_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  ampd_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  ampd_pkg::out_t out_data;

  ampdu_deaggregator_fcs_check uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  byte_req_t      byte_requests[$];
  ampd_pkg::out_t expected_reports[$];
  logic [7:0]     frame[$];
  int             failures = 0;

  // ---------------------------------------------------------------- parser
  parse_e      parse_st = PARSE_IDLE;
  logic [31:0] crc_acc = ampd_pkg::CRC_INIT;
  logic [11:0] byte_pos = '0;
  logic [11:0] psdu_len = '0;
  logic [11:0] body_start = '0;
  logic [1:0]  delim_idx = '0;
  logic        eof_flag = 1'b0;
  logic [13:0] delim_len = '0;
  logic [13:0] body_left = '0;

  function automatic logic [31:0] crc32_update(logic [31:0] c, logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = c >> 1;
      if (fb) c = c ^ ampd_pkg::CRC_POLY;
    end
    return c;
  endfunction

  function automatic ampd_pkg::out_t make_report(logic [11:0] off, logic [11:0] len,
                                                 logic agg);
    ampd_pkg::out_t r;
    r.mpdu_offset    = off;
    r.mpdu_length    = len;
    r.fcs_ok         = (~crc_acc == ampd_pkg::GOOD_FCS);
    r.from_aggregate = agg;
    return r;
  endfunction

  task automatic parse_psdu_byte(input ampd_pkg::in_t req);
    int pos;
    if (req.first_byte) begin
      // 12-bit length never exceeds the 4095 clamp
      psdu_len   = req.psdu_length;
      byte_pos   = '0;
      eof_flag   = 1'b0;
      delim_idx  = '0;
      delim_len  = '0;
      body_left  = '0;
      body_start = '0;
      crc_acc    = ampd_pkg::CRC_INIT;
      if (req.psdu_length == 0) parse_st = PARSE_IDLE;
      else parse_st = req.aggregated ? PARSE_DELIM : PARSE_PLAIN;
    end
    pos = byte_pos;
    case (parse_st)
      PARSE_PLAIN: begin
        crc_acc = crc32_update(crc_acc, req.data_byte);
        if (pos + 1 >= psdu_len) begin
          expected_reports.push_back(make_report(12'd0, psdu_len, 1'b0));
          parse_st = PARSE_IDLE;
        end
        byte_pos = 12'(pos + 1);
      end
      PARSE_DELIM: begin
        if (delim_idx == 2'd0 && psdu_len < pos + ampd_pkg::DELIM_BYTES) begin
          parse_st = PARSE_IDLE;
        end else if (delim_idx == 2'd3 && psdu_len < pos + 1 + delim_len) begin
          // mpdu would run past the psdu end
          parse_st  = PARSE_IDLE;
          delim_idx = 2'd0;
        end else begin
          case (delim_idx)
            2'd0: begin
              eof_flag  = req.data_byte[0];
              delim_len = {req.data_byte[3:2], 8'h00, req.data_byte[7:4]};
            end
            2'd1: delim_len[11:4] = req.data_byte;
            2'd3: begin
              crc_acc = ampd_pkg::CRC_INIT;
              if (delim_len == 0) begin
                expected_reports.push_back(make_report(12'(pos + 1), 12'd0, 1'b1));
                if (eof_flag) parse_st = PARSE_IDLE;
              end else begin
                parse_st   = PARSE_BODY;
                body_left  = delim_len;
                body_start = 12'(pos + 1);
              end
            end
            default: ;
          endcase
          delim_idx = delim_idx + 2'd1;
          byte_pos  = 12'(pos + 1);
        end
      end
      PARSE_BODY: begin
        crc_acc   = crc32_update(crc_acc, req.data_byte);
        body_left = body_left - 14'd1;
        if (body_left == 0) begin
          expected_reports.push_back(make_report(body_start, delim_len[11:0], 1'b1));
          parse_st  = eof_flag ? PARSE_IDLE : PARSE_DELIM;
          delim_idx = 2'd0;
        end
        byte_pos = 12'(pos + 1);
      end
      default: ;
    endcase
  endtask

  // ------------------------------------------------------------- stimulus
  task automatic push_req(logic [7:0] d, logic f, logic [11:0] l, logic a, bit drain);
    byte_req_t r;
    r.req.data_byte   = d;
    r.req.first_byte  = f;
    r.req.psdu_length = l;
    r.req.aggregated  = a;
    r.hold_for_drain  = drain;
    byte_requests.push_back(r);
  endtask

  // random body; when good and len >= 4, the last four bytes carry a valid fcs
  task automatic add_mpdu(int len, bit good);
    logic [31:0] c;
    int base, idx;
    base = frame.size();
    c = ampd_pkg::CRC_INIT;
    for (int i = 0; i < len; i++) frame.push_back(8'($urandom));
    if (len >= 4) begin
      for (int i = 0; i < len - 4; i++) c = crc32_update(c, frame[base + i]);
      c = ~c;
      for (int i = 0; i < 4; i++) frame[base + len - 4 + i] = c[8*i +: 8];
    end
    if (!good && len > 0) begin
      idx = base + $urandom_range(0, len - 1);
      frame[idx] = frame[idx] ^ (8'h01 << $urandom_range(0, 7));
    end
  endtask

  task automatic add_delim(int len, bit eof);
    logic [13:0] l;
    l = 14'(len);
    frame.push_back({l[3:0], l[13:12], 1'($urandom), eof});
    frame.push_back(l[11:4]);
    frame.push_back(8'($urandom));
    frame.push_back(8'($urandom));
  endtask

  // sends cnt bytes of the frame, random filler past its end
  task automatic send_psdu(int plen, logic agg, int cnt, bit drain);
    logic [7:0] d;
    for (int i = 0; i < cnt; i++) begin
      d = (i < frame.size()) ? frame[i] : 8'($urandom);
      if (i == 0) push_req(d, 1'b1, 12'(plen), agg, drain);
      else push_req(d, 1'b0, 12'($urandom), 1'($urandom), 1'b0);
    end
  endtask

  task automatic fill_random(int n);
    int target, kind, nm, mlen, ending, plen, cnt, room;
    bit drain;
    target = byte_requests.size() + n;
    while (byte_requests.size() < target) begin
      drain = ($urandom_range(0, 39) == 0);
      kind  = $urandom_range(0, 19);
      frame.delete();
      if (kind < 2) begin
        // zero length psdu, all its bytes are dropped
        send_psdu(0, 1'($urandom), $urandom_range(1, 3), drain);
      end else if (kind < 9) begin
        plen = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 64);
        add_mpdu(plen, $urandom_range(0, 3) != 0);
        cnt = plen;
        case ($urandom_range(0, 9))
          0: cnt = $urandom_range(1, plen);
          1: cnt = plen + $urandom_range(1, 4);
          default: ;
        endcase
        send_psdu(plen, 1'b0, cnt, drain);
      end else begin
        nm     = $urandom_range(1, 4);
        ending = $urandom_range(0, 9);
        for (int k = 0; k < nm; k++) begin
          case ($urandom_range(0, 9))
            0: mlen = 0;
            1: mlen = $urandom_range(1, 3);
            default: mlen = $urandom_range(4, 48);
          endcase
          add_delim(mlen, k == nm - 1 && (ending < 6 || ending == 9));
          add_mpdu(mlen, $urandom_range(0, 4) != 0);
        end
        // no eof: leftover tail too short for a delimiter
        if (ending == 6) repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom));
        // delimiter whose mpdu runs past the end
        if (ending == 7) begin
          mlen = $urandom_range(0, 1) ? $urandom_range(64, 16383) : $urandom_range(1, 40);
          add_delim(mlen, 1'($urandom));
          room = $urandom_range(0, (mlen > 40) ? 40 : mlen - 1);
          repeat (room) frame.push_back(8'($urandom));
        end
        plen = frame.size();
        cnt  = plen;
        if (ending == 8) cnt = $urandom_range(1, plen);
        if (ending == 9) cnt = plen + $urandom_range(1, 3);
        send_psdu(plen, 1'b1, cnt, drain);
      end
    end
  endtask

  // ---------------------------------------------------------------- driver
  logic in_fire = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // request still pending, hold it
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left = gap_left - 1;
    end else if (byte_requests.size() == 0 ||
                 (byte_requests[0].hold_for_drain && expected_reports.size() != 0)) begin
      in_valid <= 1'b0;
    end else begin
      in_data  <= byte_requests[0].req;
      in_valid <= 1'b1;
      void'(byte_requests.pop_front());
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 48);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      end else begin
        burst_left = burst_left - 1;
      end
    end
  end

  // -------------------------------------------------------------- receiver
  int       rx_cycle = 0;
  int       rx_hold = 0;
  int       rx_mode_left = 0;
  rx_mode_e rx_mode = RX_FREE;
  logic     rx_rdy;

  always @(negedge clk) begin
    rx_cycle = rx_cycle + 1;
    // long hold-off so the block backs up into its input
    if (rx_cycle % 3000 == 300) rx_hold = $urandom_range(200, 400);
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(20, 200);
    end else begin
      rx_mode_left = rx_mode_left - 1;
    end
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      rx_rdy  = 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE:   rx_rdy = 1'b1;
        RX_HALF:   rx_rdy = 1'($urandom);
        RX_SPARSE: rx_rdy = ($urandom_range(0, 3) == 0);
        default:   rx_rdy = (rx_cycle % 3) != 0;
      endcase
    end
    out_ready <= rx_rdy;
  end

  // --------------------------------------------------------------- monitor
  ampd_pkg::out_t want_rpt;

  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) parse_psdu_byte(in_data);
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        $error("report with none pending: offset %0d length %0d",
               out_data.mpdu_offset, out_data.mpdu_length);
        failures = failures + 1;
      end else begin
        want_rpt = expected_reports.pop_front();
        if (out_data.mpdu_offset !== want_rpt.mpdu_offset) begin
          $error("mpdu_offset: expected %0d, got %0d", want_rpt.mpdu_offset,
                 out_data.mpdu_offset);
          failures = failures + 1;
        end
        if (out_data.mpdu_length !== want_rpt.mpdu_length) begin
          $error("mpdu_length: expected %0d, got %0d", want_rpt.mpdu_length,
                 out_data.mpdu_length);
          failures = failures + 1;
        end
        if (out_data.fcs_ok !== want_rpt.fcs_ok) begin
          $error("fcs_ok: expected %0b, got %0b", want_rpt.fcs_ok, out_data.fcs_ok);
          failures = failures + 1;
        end
        if (out_data.from_aggregate !== want_rpt.from_aggregate) begin
          $error("from_aggregate: expected %0b, got %0b", want_rpt.from_aggregate,
                 out_data.from_aggregate);
          failures = failures + 1;
        end
      end
    end
  end

  // -------------------------------------------------------------- watchdog
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL ampdu_deaggregator_fcs_check");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ------------------------------------------------------------- sequence
  initial begin
    int mlen;
    int mark;

    // stray byte while nothing is open
    push_req(8'hFF, 1'b0, 12'hFFF, 1'b1, 1'b0);
    // empty psdu
    frame.delete();
    send_psdu(0, 1'b1, 2, 1'b0);
    // one-byte plain psdu
    frame.push_back(8'hFF);
    send_psdu(1, 1'b0, 1, 1'b0);
    // plain psdu with good fcs
    frame.delete();
    add_mpdu(5, 1'b1);
    send_psdu(5, 1'b0, 5, 1'b0);
    // zero-length mpdu, then a good one closing with eof
    frame.delete();
    add_delim(0, 1'b0);
    add_delim(4, 1'b1);
    add_mpdu(4, 1'b1);
    send_psdu(12, 1'b1, 12, 1'b0);
    // aggregate too short for a delimiter
    frame.delete();
    repeat (3) frame.push_back(8'hFF);
    send_psdu(3, 1'b1, 3, 1'b0);
    // longest psdu, restarted after one byte
    frame.delete();
    frame.push_back(8'h00);
    send_psdu(4095, 1'b0, 1, 1'b0);

    mark = byte_requests.size();
    fill_random(400);
    // directed results all in before random traffic starts
    byte_requests[mark].hold_for_drain = 1'b1;

    // long plain psdu
    frame.delete();
    add_mpdu(512, 1'b1);
    send_psdu(512, 1'b0, 512, 1'b0);
    // long aggregate ending with a zero-length mpdu at the last offset
    frame.delete();
    while (frame.size() < 400) begin
      mlen = $urandom_range(0, 60);
      add_delim(mlen, 1'b0);
      add_mpdu(mlen, $urandom_range(0, 4) != 0);
    end
    mlen = 512 - frame.size() - 8;
    add_delim(mlen, 1'b0);
    add_mpdu(mlen, 1'b1);
    add_delim(0, 1'b1);
    send_psdu(512, 1'b1, 512, 1'b0);

    fill_random(400);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (byte_requests.size() != 0 || in_valid) @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (failures == 0) begin
      $display("PASS ampdu_deaggregator_fcs_check");
    end else begin
      $display("FAIL ampdu_deaggregator_fcs_check");
    end
    $finish;
  end

endmodule
